@@ design/gwa_pkg.sv @@
// shared types, field widths and codes of the greedy weighted assignment block
package gwa_pkg;

  localparam int MAX_AGENTS_DEF = 16;
  localparam int MAX_JOBS_DEF   = 1023;

  localparam int KIND_W      = 2;
  localparam int AGENT_W     = 4;
  localparam int COST_W      = 16;
  localparam int RES_W       = 16;
  localparam int CAP_W       = 20;
  localparam int TOTAL_W     = 26;
  localparam int WEIGHT_W    = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int PROD_W      = WEIGHT_W + COST_W + 1;
  localparam int SCORE_W     = PROD_W + 1;

  localparam logic [TOTAL_W-1:0]  COST_MAX     = '1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;

  localparam logic [KIND_W-1:0] KIND_START    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CAPACITY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_JOB      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FINISH   = 2'd3;

  localparam logic RES_JOB      = 1'b0;
  localparam logic RES_INSTANCE = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_COST     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_RESOURCE = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [AGENT_W-1:0] agent;
    logic [COST_W-1:0]  cost;
    logic [RES_W-1:0]   resource;
    logic [CAP_W-1:0]   capacity_value;
    logic               last_of_job;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic [AGENT_W-1:0] chosen_agent;
    logic               placed;
    logic [TOTAL_W-1:0] total_cost;
    logic               all_placed;
  } out_item_t;

  typedef struct packed {
    logic             cap_we;
    logic             elem_we;
    logic             clr_usage;
    logic             clr_valid;
    logic [COST_W-1:0] cost;
    logic [RES_W-1:0]  res;
    logic [CAP_W-1:0]  cap;
  } agent_wr_t;

  typedef struct packed {
    logic              valid;
    logic [COST_W-1:0] cost;
    logic [RES_W-1:0]  res;
    logic [CAP_W-1:0]  cap;
    logic [CAP_W-1:0]  usage;
  } agent_rd_t;

  typedef struct packed {
    logic              valid;
    logic              phase;
    logic              elig;
    logic [COST_W-1:0] cost;
    logic [RES_W-1:0]  res;
  } scan_issue_t;

  typedef struct packed {
    logic              found;
    logic [COST_W-1:0] cost;
    logic [RES_W-1:0]  res;
  } scan_best_t;

endpackage

@@ design/greedy_weighted_assignment.sv @@
// greedy weighted assignment top level: item decode, scan sequencer and result register
// start, capacity, partial job element, finish and at-limit job end items are handled in idle
// a job end under the job limit scans the agents: one shared multiplier forms the two score
// terms of each agent in turn, then a 2 stage drain before the result is registered
// results are held in an output register; the next item waits during a scan or drain, or while the result is stalled
// synchronous active-low reset: weights 256, capacities, usage and counters zero
module greedy_weighted_assignment #(
  parameter int MAX_AGENTS = gwa_pkg::MAX_AGENTS_DEF,
  parameter int MAX_JOBS   = gwa_pkg::MAX_JOBS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gwa_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gwa_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [gwa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gwa_pkg::WEIGHT_W-1:0]    cfg_data
);
  import gwa_pkg::*;

  localparam int AW = $clog2(MAX_AGENTS);
  localparam int IW = (AW > AGENT_W) ? AW : AGENT_W;
  localparam int JW = $clog2(MAX_JOBS + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_AGENTS - 1);
  localparam logic [JW-1:0] JOB_LIMIT = JW'(MAX_JOBS);

  state_t state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          ph_r, ph_nxt;

  logic signed [WEIGHT_W-1:0] wc_r, wr_r;
  logic [TOTAL_W-1:0] rc_r, rc_nxt;
  logic [JW-1:0]      seen_r, seen_nxt;
  logic [JW-1:0]      placed_r, placed_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  out_item_t out_load;
  logic      load;

  agent_wr_t   wr;
  agent_rd_t   rd;
  logic        upd_we;
  scan_issue_t issue;
  scan_best_t  best;
  logic [AW-1:0] best_idx;
  logic        unit_clear;
  logic        busy;

  logic          in_acc;
  logic          out_free;
  logic          agent_ok;
  logic [IW-1:0] agent_ext;
  logic [IW-1:0] best_ext;
  logic [AW-1:0] wr_idx;
  logic [TOTAL_W:0] cost_sum;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign cfg_ready = 1'b1;
  assign agent_ok  = 32'(in_data.agent) < MAX_AGENTS;
  assign agent_ext = IW'(in_data.agent);
  assign wr_idx    = agent_ext[AW-1:0];
  assign best_ext  = IW'(best_idx);
  assign cost_sum  = {1'b0, rc_r} + (TOTAL_W + 1)'(best.cost);

  assign issue.valid = (state_r == ST_SCAN);
  assign issue.phase = ph_r;
  assign issue.cost  = rd.cost;
  assign issue.res   = rd.res;
  assign issue.elig  = rd.valid &&
                       (({1'b0, rd.usage} + (CAP_W + 1)'(rd.res)) <= {1'b0, rd.cap});

  gwa_agent_store #(
    .MAX_AGENTS(MAX_AGENTS)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .wr_idx (wr_idx),
    .upd_we (upd_we),
    .upd_idx(best_idx),
    .upd_res(best.res),
    .rd_idx (idx_r),
    .rd     (rd)
  );

  gwa_min_unit #(
    .MAX_AGENTS(MAX_AGENTS)
  ) u_min (
    .clk            (clk),
    .rst_n          (rst_n),
    .clear          (unit_clear),
    .issue          (issue),
    .issue_idx      (idx_r),
    .weight_cost    (wc_r),
    .weight_resource(wr_r),
    .busy           (busy),
    .best           (best),
    .best_idx       (best_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r <= WEIGHT_RESET;
      wr_r <= WEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WEIGHT_COST:     wc_r <= cfg_data;
        CFG_WEIGHT_RESOURCE: wr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    ph_nxt     = ph_r;
    rc_nxt     = rc_r;
    seen_nxt   = seen_r;
    placed_nxt = placed_r;
    unit_clear = 1'b0;
    upd_we     = 1'b0;
    load       = 1'b0;
    out_load   = '0;
    wr         = '0;
    wr.cost    = in_data.cost;
    wr.res     = in_data.resource;
    wr.cap     = in_data.capacity_value;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data.kind)
            KIND_START: begin
              wr.clr_usage = 1'b1;
              wr.clr_valid = 1'b1;
              rc_nxt       = '0;
              seen_nxt     = '0;
              placed_nxt   = '0;
            end
            KIND_CAPACITY: begin
              wr.cap_we = agent_ok;
            end
            KIND_JOB: begin
              wr.elem_we = agent_ok;
              if (in_data.last_of_job) begin
                if (seen_r >= JOB_LIMIT) begin
                  placed_nxt   = '0;
                  wr.clr_valid = 1'b1;
                  load         = 1'b1;
                  out_load.result_kind = RES_JOB;
                end else begin
                  seen_nxt   = seen_r + 1'b1;
                  unit_clear = 1'b1;
                  idx_nxt    = '0;
                  ph_nxt     = 1'b0;
                  state_nxt  = ST_SCAN;
                end
              end
            end
            KIND_FINISH: begin
              wr.clr_valid = 1'b1;
              load         = 1'b1;
              out_load.result_kind = RES_INSTANCE;
              out_load.all_placed  = (placed_r == seen_r);
              out_load.total_cost  = (placed_r == seen_r) ? rc_r : '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!busy && out_free) begin
          if (best.found) begin
            upd_we     = 1'b1;
            rc_nxt     = (cost_sum > {1'b0, COST_MAX}) ? COST_MAX : cost_sum[TOTAL_W-1:0];
            placed_nxt = placed_r + 1'b1;
            out_load.chosen_agent = best_ext[AGENT_W-1:0];
            out_load.placed       = 1'b1;
          end
          wr.clr_valid = 1'b1;
          load         = 1'b1;
          out_load.result_kind = RES_JOB;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      ph_r        <= 1'b0;
      rc_r        <= '0;
      seen_r      <= '0;
      placed_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      ph_r        <= ph_nxt;
      rc_r        <= rc_nxt;
      seen_r      <= seen_nxt;
      placed_r    <= placed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_load;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_data.kind == KIND_JOB) && in_data.last_of_job && (seen_r < JOB_LIMIT))
    |=> (state_r == ST_SCAN))
    else $error("job end under the limit did not start a scan");

  a_drain_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DRAIN) && !busy && out_free)
    |=> (out_valid && (out_data.result_kind == RES_JOB) && (state_r == ST_IDLE)))
    else $error("scan end did not register a job result");

  a_job_counts: assert property (@(posedge clk) disable iff (!rst_n)
    placed_r <= seen_r)
    else $error("placed job count above seen job count");
`endif

endmodule

@@ design/gwa_agent_store.sv @@
// per-agent capacity, usage and pending job element storage
module gwa_agent_store #(
  parameter int MAX_AGENTS = gwa_pkg::MAX_AGENTS_DEF,
  localparam int AW = $clog2(MAX_AGENTS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gwa_pkg::agent_wr_t  wr,
  input  logic [AW-1:0]       wr_idx,
  input  logic                upd_we,
  input  logic [AW-1:0]       upd_idx,
  input  logic [gwa_pkg::RES_W-1:0] upd_res,
  input  logic [AW-1:0]       rd_idx,
  output gwa_pkg::agent_rd_t  rd
);
  import gwa_pkg::*;

  logic [CAP_W-1:0]  cap_r   [MAX_AGENTS];
  logic [CAP_W-1:0]  usage_r [MAX_AGENTS];
  logic [COST_W-1:0] cost_r  [MAX_AGENTS];
  logic [RES_W-1:0]  res_r   [MAX_AGENTS];
  logic [MAX_AGENTS-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_AGENTS; i++) begin
        cap_r[i]   <= '0;
        usage_r[i] <= '0;
      end
      valid_r <= '0;
    end else begin
      if (wr.cap_we) begin
        cap_r[wr_idx] <= wr.cap;
      end
      if (wr.clr_usage) begin
        for (int i = 0; i < MAX_AGENTS; i++) begin
          usage_r[i] <= '0;
        end
      end else if (upd_we) begin
        usage_r[upd_idx] <= usage_r[upd_idx] + CAP_W'(upd_res);
      end
      if (wr.clr_valid) begin
        valid_r <= '0;
      end else if (wr.elem_we) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  // pending element values, only read behind their valid bit
  always_ff @(posedge clk) begin
    if (wr.elem_we) begin
      cost_r[wr_idx] <= wr.cost;
      res_r[wr_idx]  <= wr.res;
    end
  end

  always_comb begin
    rd.valid = valid_r[rd_idx];
    rd.cost  = cost_r[rd_idx];
    rd.res   = res_r[rd_idx];
    rd.cap   = cap_r[rd_idx];
    rd.usage = usage_r[rd_idx];
  end

endmodule

@@ design/gwa_min_unit.sv @@
// shared multiplier, score accumulator and running minimum over the agents
module gwa_min_unit #(
  parameter int MAX_AGENTS = gwa_pkg::MAX_AGENTS_DEF,
  localparam int AW = $clog2(MAX_AGENTS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clear,
  input  gwa_pkg::scan_issue_t issue,
  input  logic [AW-1:0]        issue_idx,
  input  logic signed [gwa_pkg::WEIGHT_W-1:0] weight_cost,
  input  logic signed [gwa_pkg::WEIGHT_W-1:0] weight_resource,
  output logic                 busy,
  output gwa_pkg::scan_best_t  best,
  output logic [AW-1:0]        best_idx
);
  import gwa_pkg::*;

  logic signed [WEIGHT_W-1:0] w_sel;
  logic signed [COST_W:0]     opnd;
  logic signed [PROD_W-1:0]   prod;

  logic                     v1_r;
  logic                     ph1_r;
  logic signed [PROD_W-1:0] prod1_r;
  logic [AW-1:0]            idx1_r;
  logic                     el1_r;
  logic [COST_W-1:0]        cost1_r;
  logic [RES_W-1:0]         res1_r;

  logic signed [PROD_W-1:0]  acc_r;
  logic                      v2_r;
  logic signed [SCORE_W-1:0] score2_r;
  logic [AW-1:0]             idx2_r;
  logic                      el2_r;
  logic [COST_W-1:0]         cost2_r;
  logic [RES_W-1:0]          res2_r;

  logic                      found_r;
  logic signed [SCORE_W-1:0] best_score_r;
  logic [AW-1:0]             best_idx_r;
  logic [COST_W-1:0]         best_cost_r;
  logic [RES_W-1:0]          best_res_r;

  // cost term on the first phase, resource term on the second
  always_comb begin
    w_sel = issue.phase ? weight_resource : weight_cost;
    opnd  = $signed({1'b0, (issue.phase ? issue.res : issue.cost)});
    prod  = w_sel * opnd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      found_r <= 1'b0;
    end else if (clear) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      v1_r <= issue.valid;
      v2_r <= v1_r && ph1_r;
      if (v2_r && el2_r && (!found_r || (score2_r < best_score_r))) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ph1_r   <= issue.phase;
    prod1_r <= prod;
    idx1_r  <= issue_idx;
    el1_r   <= issue.elig;
    cost1_r <= issue.cost;
    res1_r  <= issue.res;
    if (v1_r && !ph1_r) begin
      acc_r <= prod1_r;
    end
    score2_r <= SCORE_W'(acc_r) + SCORE_W'(prod1_r);
    idx2_r   <= idx1_r;
    el2_r    <= el1_r;
    cost2_r  <= cost1_r;
    res2_r   <= res1_r;
    // strict compare keeps the lower index on a tie
    if (v2_r && el2_r && (!found_r || (score2_r < best_score_r))) begin
      best_score_r <= score2_r;
      best_idx_r   <= idx2_r;
      best_cost_r  <= cost2_r;
      best_res_r   <= res2_r;
    end
  end

  assign busy       = v1_r || v2_r;
  assign best.found = found_r;
  assign best.cost  = best_cost_r;
  assign best.res   = best_res_r;
  assign best_idx   = best_idx_r;

endmodule
